// ===== sv/prcu_pkg.sv =====
package prcu_pkg;

  localparam int RULE_SLOTS_DEF = 32;
  localparam int SUBSTANCES_DEF = 8;
  localparam int COUNT_BITS_DEF = 6;

  // counts are at most 8 bits, bounds are 8-bit signed: 10 bits hold any difference
  localparam int DIFF_W = 10;

  localparam logic [3:0] SCAN_RESET = 4'd8;

  typedef enum logic [2:0] {
    CMD_RULE,
    CMD_COMPOSE,
    CMD_DECOMPOSE,
    CMD_NEIGHBOR,
    CMD_EVALUATE
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMASK,
    ST_FETCH,
    ST_OBJ,
    ST_SUB,
    ST_DMASK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] object;
    logic [2:0] subtracter;
    logic [2:0] result;
    logic [7:0] low;
    logic [7:0] high;
  } rule_t;

  // request decoded by the top level for the sequencer
  typedef struct packed {
    logic        start;
    logic        cwr;
    logic        dwr;
    logic [4:0]  index;
    logic [31:0] mask;
    logic [2:0]  target;
  } ctl_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== sv/prcu_rule_mem.sv =====
module prcu_rule_mem #(
  parameter int RULE_SLOTS = prcu_pkg::RULE_SLOTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [prcu_pkg::idx_w(RULE_SLOTS)-1:0] wr_addr,
  input  prcu_pkg::rule_t                        wr_data,
  input  logic                                   rd_en,
  input  logic [prcu_pkg::idx_w(RULE_SLOTS)-1:0] rd_addr,
  output prcu_pkg::rule_t                        rd_data
);
  import prcu_pkg::*;

  rule_t mem [RULE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/prcu_counts.sv =====
module prcu_counts #(
  parameter int SUBSTANCES = prcu_pkg::SUBSTANCES_DEF,
  parameter int COUNT_BITS = prcu_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  inc,
  input  logic [6:0]            attrs,
  input  logic                  clr,
  input  logic [2:0]            rd_sub,
  output logic [COUNT_BITS-1:0] rd_data
);
  import prcu_pkg::*;

  localparam int SIDX_W = idx_w(SUBSTANCES);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [COUNT_BITS-1:0] counts [SUBSTANCES];
  logic [15:0]           aw;
  logic [7:0]            sw;

  assign aw = 16'(attrs);
  assign sw = 8'(rd_sub);

  // substances beyond the store read as zero
  assign rd_data = (int'(rd_sub) < SUBSTANCES) ? counts[sw[SIDX_W-1:0]] : '0;

  // lane 0 is never incremented and stays zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int k = 0; k < SUBSTANCES; k++) begin
        counts[k] <= '0;
      end
    end else if (inc) begin
      for (int k = 1; k < SUBSTANCES; k++) begin
        if (k <= 7 && aw[k-1] && counts[k] != CMAX) begin
          counts[k] <= counts[k] + COUNT_BITS'(1);
        end
      end
    end
  end

endmodule

// ===== sv/prcu_seq.sv =====
module prcu_seq #(
  parameter int RULE_SLOTS = prcu_pkg::RULE_SLOTS_DEF,
  parameter int SUBSTANCES = prcu_pkg::SUBSTANCES_DEF,
  parameter int COUNT_BITS = prcu_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  prcu_pkg::ctl_t                         ctl,
  input  logic [3:0]                             scan_cfg,
  output logic                                   idle,
  output logic                                   rd_en,
  output logic [prcu_pkg::idx_w(RULE_SLOTS)-1:0] rd_addr,
  input  prcu_pkg::rule_t                        rule,
  output logic [2:0]                             cnt_sub,
  input  logic [COUNT_BITS-1:0]                  cnt_data,
  output logic                                   cnt_clr,
  output logic                                   res_valid,
  output logic [2:0]                             res_value,
  input  logic                                   res_take
);
  import prcu_pkg::*;

  localparam int RIDX_W = idx_w(RULE_SLOTS);
  localparam int SIDX_W = idx_w(SUBSTANCES);
  localparam int SC_W   = $clog2(SUBSTANCES + 1);

  state_t state, state_next;

  logic [RULE_SLOTS-1:0] cmasks [SUBSTANCES];
  logic [RULE_SLOTS-1:0] dmasks [SUBSTANCES];

  logic [RULE_SLOTS-1:0] work, work_next;
  logic [SC_W-1:0]       scan_left, scan_left_next;
  logic                  compose, compose_next;
  logic [2:0]            target, target_next;
  logic [2:0]            result, result_next;
  logic [COUNT_BITS-1:0] cnt_a, cnt_a_next;

  logic [RIDX_W-1:0]     first_idx;
  logic [7:0]            ew;
  logic [63:0]           mask_w;
  logic [RULE_SLOTS-1:0] new_mask;
  logic [SC_W-1:0]       scan_init;
  logic [SC_W-1:0]       scan_dec;
  logic [7:0]            sel_w;
  logic [7:0]            tw;
  logic [RULE_SLOTS-1:0] cmask_rd, dmask_rd;
  logic                  tgt_ok;
  logic signed [DIFF_W-1:0] diff, lo, hi;
  logic [2:0]            react;

  assign ew        = 8'(ctl.index);
  assign mask_w    = 64'(ctl.mask);
  assign new_mask  = mask_w[RULE_SLOTS-1:0];
  assign scan_init = (int'(scan_cfg) < SUBSTANCES) ? SC_W'(scan_cfg) : SC_W'(SUBSTANCES);
  assign scan_dec  = scan_left - SC_W'(1);
  assign sel_w     = 8'(scan_dec);
  assign cmask_rd  = cmasks[sel_w[SIDX_W-1:0]];
  assign tw        = 8'(target);
  assign tgt_ok    = int'(target) < SUBSTANCES;
  assign dmask_rd  = dmasks[tw[SIDX_W-1:0]];

  // lowest pending rule of the working mask
  always_comb begin
    first_idx = '0;
    for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
      if (work[i]) begin
        first_idx = RIDX_W'(i);
      end
    end
  end

  // shared reaction unit: difference of two counts against open bounds
  assign diff  = $signed(DIFF_W'(cnt_a)) - $signed(DIFF_W'(cnt_data));
  assign lo    = DIFF_W'($signed(rule.low));
  assign hi    = DIFF_W'($signed(rule.high));
  assign react = (diff > lo && diff < hi) ? rule.result : 3'd0;

  assign idle      = state == ST_IDLE;
  assign rd_en     = state == ST_FETCH;
  assign rd_addr   = first_idx;
  assign cnt_sub   = (state == ST_OBJ) ? rule.object : rule.subtracter;
  assign res_valid = state == ST_DONE;
  assign res_value = result;
  assign cnt_clr   = (state == ST_DONE) && res_take;

  always_comb begin
    state_next     = state;
    work_next      = work;
    scan_left_next = scan_left;
    compose_next   = compose;
    target_next    = target;
    result_next    = result;
    cnt_a_next     = cnt_a;
    case (state)
      ST_IDLE: begin
        if (ctl.start) begin
          scan_left_next = scan_init;
          target_next    = ctl.target;
          state_next     = ST_CMASK;
        end
      end
      ST_CMASK: begin
        if (scan_left == '0) begin
          state_next = ST_DMASK;
        end else if (cmask_rd == '0) begin
          scan_left_next = scan_dec;
        end else begin
          work_next    = cmask_rd;
          compose_next = 1'b1;
          state_next   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        work_next  = work & ~(RULE_SLOTS'(1) << first_idx);
        state_next = ST_OBJ;
      end
      ST_OBJ: begin
        cnt_a_next = cnt_data;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        if (compose) begin
          if (react == 3'd0) begin
            scan_left_next = scan_dec;
            state_next     = ST_CMASK;
          end else if (work == '0) begin
            result_next = sel_w[2:0];
            state_next  = ST_DONE;
          end else begin
            state_next = ST_FETCH;
          end
        end else begin
          if (react != 3'd0) begin
            result_next = react;
            state_next  = ST_DONE;
          end else if (work == '0) begin
            result_next = target;
            state_next  = ST_DONE;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_DMASK: begin
        if (tgt_ok && dmask_rd != '0) begin
          work_next    = dmask_rd;
          compose_next = 1'b0;
          state_next   = ST_FETCH;
        end else begin
          result_next = target;
          state_next  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    work      <= work_next;
    scan_left <= scan_left_next;
    compose   <= compose_next;
    target    <= target_next;
    result    <= result_next;
    cnt_a     <= cnt_a_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SUBSTANCES; s++) begin
        cmasks[s] <= '0;
        dmasks[s] <= '0;
      end
    end else begin
      if (ctl.cwr && int'(ctl.index) < SUBSTANCES) begin
        cmasks[ew[SIDX_W-1:0]] <= new_mask;
      end
      if (ctl.dwr && int'(ctl.index) < SUBSTANCES) begin
        dmasks[ew[SIDX_W-1:0]] <= new_mask;
      end
    end
  end

`ifndef SYNTH
  a_fetch_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> work != '0)
    else $error("rule fetch with no rule pending");

  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && ctl.start) |=> state == ST_CMASK)
    else $error("evaluate request did not start the compose scan");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !res_take) |=> (state == ST_DONE && $stable(result)))
    else $error("pending result lost before it was taken");
`endif

endmodule

// ===== sv/programmable_rule_cell_update.sv =====
// Load and neighbour requests are accepted back to back.
// Evaluate scans the compose masks and, if no substance composes, tests the target's decompose
// rules. Each rule costs one rule table read and two count reads through the single count read port.
// Input is held off until the result moves to the output register, then taken again.
// Reset (synchronous): control idle, counts and masks zero, substance_count 8, no rule clear.
module programmable_rule_cell_update #(
  parameter int RULE_SLOTS = prcu_pkg::RULE_SLOTS_DEF,
  parameter int SUBSTANCES = prcu_pkg::SUBSTANCES_DEF,
  parameter int COUNT_BITS = prcu_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        command,
  input  logic [4:0]        entry_index,
  input  logic [2:0]        rule_object,
  input  logic [2:0]        rule_subtracter,
  input  logic [2:0]        rule_result,
  input  logic signed [7:0] rule_low,
  input  logic signed [7:0] rule_high,
  input  logic [31:0]       rule_mask,
  input  logic [6:0]        neighbor_attributes,
  input  logic [2:0]        target_substance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        next_substance,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        substance_count
);
  import prcu_pkg::*;

  localparam int RIDX_W = idx_w(RULE_SLOTS);

  logic              acc;
  logic              idle;
  ctl_t              ctl;
  logic [3:0]        scan_cfg;
  logic [7:0]        ew;
  logic              rule_we;
  rule_t             rule_wd;
  logic              rd_en;
  logic [RIDX_W-1:0] rd_addr;
  rule_t             rule_rd;
  logic [2:0]        cnt_sub;
  logic [COUNT_BITS-1:0] cnt_data;
  logic              cnt_clr;
  logic              res_valid;
  logic [2:0]        res_value;
  logic              res_take;

  assign in_ready  = idle;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign ew        = 8'(entry_index);

  assign ctl.start  = acc && command == CMD_EVALUATE;
  assign ctl.cwr    = acc && command == CMD_COMPOSE;
  assign ctl.dwr    = acc && command == CMD_DECOMPOSE;
  assign ctl.index  = entry_index;
  assign ctl.mask   = rule_mask;
  assign ctl.target = target_substance;

  assign rule_we = acc && command == CMD_RULE && int'(entry_index) < RULE_SLOTS;
  assign rule_wd = '{object: rule_object, subtracter: rule_subtracter,
                     result: rule_result, low: rule_low, high: rule_high};

  // result moves to the output register when that is empty or draining
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cfg <= SCAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scan_cfg <= substance_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      next_substance <= res_value;
    end
  end

  prcu_rule_mem #(
    .RULE_SLOTS(RULE_SLOTS)
  ) u_rule_mem (
    .clk    (clk),
    .wr_en  (rule_we),
    .wr_addr(ew[RIDX_W-1:0]),
    .wr_data(rule_wd),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rule_rd)
  );

  prcu_counts #(
    .SUBSTANCES(SUBSTANCES),
    .COUNT_BITS(COUNT_BITS)
  ) u_counts (
    .clk    (clk),
    .rst    (rst),
    .inc    (acc && command == CMD_NEIGHBOR),
    .attrs  (neighbor_attributes),
    .clr    (cnt_clr),
    .rd_sub (cnt_sub),
    .rd_data(cnt_data)
  );

  prcu_seq #(
    .RULE_SLOTS(RULE_SLOTS),
    .SUBSTANCES(SUBSTANCES),
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .scan_cfg (scan_cfg),
    .idle     (idle),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rule     (rule_rd),
    .cnt_sub  (cnt_sub),
    .cnt_data (cnt_data),
    .cnt_clr  (cnt_clr),
    .res_valid(res_valid),
    .res_value(res_value),
    .res_take (res_take)
  );

endmodule
